FILE: sv/cdsw_pkg.sv
// Shared types, command codes and segment decoding for the countdown stopwatch.
// Depends on nothing; imported by the stopwatch top level and its checker.
`default_nettype none

package cdsw_pkg;

  // Command codes carried on the input tuser.
  localparam logic [2:0] MODE_TICK     = 3'd0;
  localparam logic [2:0] MODE_RUN      = 3'd1;
  localparam logic [2:0] MODE_STOP     = 3'd2;
  localparam logic [2:0] MODE_DISP_ON  = 3'd3;
  localparam logic [2:0] MODE_DISP_OFF = 3'd4;
  localparam logic [2:0] MODE_LOAD     = 3'd5;

  // Digit positions, least significant first.
  localparam int unsigned DIG_HUND_ONES = 0;
  localparam int unsigned DIG_HUND_TENS = 1;
  localparam int unsigned DIG_SEC_ONES  = 2;
  localparam int unsigned DIG_SEC_TENS  = 3;
  localparam int unsigned DIG_MIN_ONES  = 4;
  localparam int unsigned DIG_MIN_TENS  = 5;
  localparam int unsigned NUM_DIGITS    = 6;

  localparam logic [19:0] COUNT_RESET = 20'd359999;
  localparam logic [19:0] COUNT_MAX   = 20'd603999;

  typedef logic [3:0] digit_t;
  typedef digit_t     digits_t [NUM_DIGITS];

  // Seven-segment pattern of one digit; anything above nine is blank.
  function automatic logic [7:0] seg_of(input digit_t d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'd63;
      4'd1:    s = 8'd6;
      4'd2:    s = 8'd91;
      4'd3:    s = 8'd79;
      4'd4:    s = 8'd102;
      4'd5:    s = 8'd109;
      4'd6:    s = 8'd124;
      4'd7:    s = 8'd7;
      4'd8:    s = 8'd127;
      4'd9:    s = 8'd111;
      default: s = 8'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: sv/countdown_stopwatch_seven_segment_unit.sv
// Countdown stopwatch in hundredths of a second driving six seven-segment digits.
// Each accepted input beat is registered straight into its result beat on the output.
// Throughput: one beat per cycle unless the sink stalls; the single result register is
// refilled whenever it is empty or being drained; state updates on each accepted beat.
// Reset (synchronous, active low): count 359999, shown digits zero, running, display on.
// Uses cdsw_pkg for command codes, digit positions and segment decoding.
`default_nettype none

module countdown_stopwatch_seven_segment_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [3:0] load_min_tens, [7:4] load_min_ones, [11:8] load_sec_tens,
  // [15:12] load_sec_ones, [19:16] load_hund_tens, [23:20] load_hund_ones
  input  wire logic [23:0] in_tdata,
  // [2:0] mode
  input  wire logic [2:0]  in_tuser,
  // Result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] segments_low, [47:32] segments_high, [67:48] remaining,
  // [68] is_running, [71:69] zero
  output logic [71:0]      out_tdata
);
  import cdsw_pkg::*;

  // Binary count and the same count held as normalized MM:SS:hh digits,
  // so a tick needs no division.
  logic [19:0] count_r, count_nxt;
  digits_t     cnt_dig_r, cnt_dig_nxt;
  digits_t     shown_r, shown_nxt;
  logic        run_r, run_nxt;
  logic        disp_r, disp_nxt;

  logic        out_valid_r;
  logic [71:0] out_data_r, out_data_nxt;

  logic        accept;
  digit_t      ld_dig [NUM_DIGITS];
  logic        ld_ok;
  digits_t     ld_norm;
  digits_t     dec_dig;
  logic        borrow;
  logic [6:0]  ld_min;
  logic [12:0] ld_sec;
  logic [19:0] ld_count;
  logic [31:0] seg_low;
  logic [15:0] seg_high;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Unpack the load digits into display order.
  assign ld_dig[DIG_MIN_TENS]  = in_tdata[3:0];
  assign ld_dig[DIG_MIN_ONES]  = in_tdata[7:4];
  assign ld_dig[DIG_SEC_TENS]  = in_tdata[11:8];
  assign ld_dig[DIG_SEC_ONES]  = in_tdata[15:12];
  assign ld_dig[DIG_HUND_TENS] = in_tdata[19:16];
  assign ld_dig[DIG_HUND_ONES] = in_tdata[23:20];

  assign ld_ok = (ld_dig[0] <= 4'd9) && (ld_dig[1] <= 4'd9) && (ld_dig[2] <= 4'd9)
              && (ld_dig[3] <= 4'd9) && (ld_dig[4] <= 4'd9) && (ld_dig[5] <= 4'd9);

  // Binary value of a load: constant multiplies only.
  assign ld_min   = {3'd0, ld_dig[DIG_MIN_TENS]} * 7'd10 + {3'd0, ld_dig[DIG_MIN_ONES]};
  assign ld_sec   = {6'd0, ld_min} * 13'd60
                  + {9'd0, ld_dig[DIG_SEC_TENS]} * 13'd10 + {9'd0, ld_dig[DIG_SEC_ONES]};
  assign ld_count = {7'd0, ld_sec} * 20'd100
                  + {16'd0, ld_dig[DIG_HUND_TENS]} * 20'd10
                  + {16'd0, ld_dig[DIG_HUND_ONES]};

  // Normalize loaded digits: seconds of sixty or more carry into the minutes.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      ld_norm[i] = ld_dig[i];
    end
    if (ld_dig[DIG_SEC_TENS] >= 4'd6) begin
      ld_norm[DIG_SEC_TENS] = ld_dig[DIG_SEC_TENS] - 4'd6;
      if (ld_dig[DIG_MIN_ONES] == 4'd9) begin
        ld_norm[DIG_MIN_ONES] = 4'd0;
        ld_norm[DIG_MIN_TENS] = ld_dig[DIG_MIN_TENS] + 4'd1;
      end else begin
        ld_norm[DIG_MIN_ONES] = ld_dig[DIG_MIN_ONES] + 4'd1;
      end
    end
  end

  // Mixed-radix decrement of the count digits; only used on a nonzero count.
  always_comb begin
    borrow = 1'b1;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dec_dig[i] = cnt_dig_r[i];
      if (borrow) begin
        if (cnt_dig_r[i] != 4'd0 || i == DIG_MIN_TENS) begin
          dec_dig[i] = cnt_dig_r[i] - 4'd1;
          borrow     = 1'b0;
        end else if (i == DIG_SEC_TENS) begin
          dec_dig[i] = 4'd5;
        end else begin
          dec_dig[i] = 4'd9;
        end
      end
    end
  end

  // Command decode and next state.
  always_comb begin
    count_nxt   = count_r;
    cnt_dig_nxt = cnt_dig_r;
    shown_nxt   = shown_r;
    run_nxt     = run_r;
    disp_nxt    = disp_r;
    case (in_tuser)
      MODE_TICK: begin
        if (run_r) begin
          shown_nxt = cnt_dig_r;
          if (count_r != 20'd0) begin
            count_nxt   = count_r - 20'd1;
            cnt_dig_nxt = dec_dig;
          end
        end
      end
      MODE_RUN:      run_nxt  = 1'b1;
      MODE_STOP:     run_nxt  = 1'b0;
      MODE_DISP_ON:  disp_nxt = 1'b1;
      MODE_DISP_OFF: disp_nxt = 1'b0;
      MODE_LOAD: begin
        if (ld_ok) begin
          count_nxt   = ld_count;
          cnt_dig_nxt = ld_norm;
          for (int i = 0; i < NUM_DIGITS; i++) begin
            shown_nxt[i] = ld_dig[i];
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Segment bytes of the new display contents.
  always_comb begin
    seg_low  = '0;
    seg_high = '0;
    if (disp_nxt) begin
      seg_low  = {seg_of(shown_nxt[DIG_SEC_TENS]), seg_of(shown_nxt[DIG_SEC_ONES]),
                  seg_of(shown_nxt[DIG_HUND_TENS]), seg_of(shown_nxt[DIG_HUND_ONES])};
      seg_high = {seg_of(shown_nxt[DIG_MIN_TENS]), seg_of(shown_nxt[DIG_MIN_ONES])};
    end
  end

  assign out_data_nxt = {3'd0, run_nxt, count_nxt, seg_high, seg_low};

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
      cnt_dig_r[DIG_HUND_ONES] <= 4'd9;
      cnt_dig_r[DIG_HUND_TENS] <= 4'd9;
      cnt_dig_r[DIG_SEC_ONES]  <= 4'd9;
      cnt_dig_r[DIG_SEC_TENS]  <= 4'd5;
      cnt_dig_r[DIG_MIN_ONES]  <= 4'd9;
      cnt_dig_r[DIG_MIN_TENS]  <= 4'd5;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        shown_r[i] <= 4'd0;
      end
      run_r  <= 1'b1;
      disp_r <= 1'b1;
    end else if (accept) begin
      count_r   <= count_nxt;
      cnt_dig_r <= cnt_dig_nxt;
      shown_r   <= shown_nxt;
      run_r     <= run_nxt;
      disp_r    <= disp_nxt;
    end
  end

  // Result register: holds a beat until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

FILE: sv/cdsw_checker.sv
// Port-level checker for the countdown stopwatch, bound to its top level.
// Depends on cdsw_pkg for the command codes and the count limit.
`default_nettype none

module cdsw_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [2:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata
);
  import cdsw_pkg::*;

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The count never exceeds the largest loadable value.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[67:48] <= COUNT_MAX)
    else $error("remaining count out of range");

  // A stop command yields a result that reports the block stopped.
  a_stop_flag: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == MODE_STOP |=> out_tvalid && !out_tdata[68])
    else $error("stop not reflected in result");

  // Blanking the display yields all-dark segments.
  a_blank: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser == MODE_DISP_OFF |=> out_tvalid && out_tdata[47:0] == 48'd0)
    else $error("segments lit while display is off");

endmodule

bind countdown_stopwatch_seven_segment_unit cdsw_checker u_cdsw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

FILE: tb/sv/tb_countdown_stopwatch_seven_segment_unit.sv
// Self-checking testbench for the countdown stopwatch unit: directed and random commands,
// random gaps and backpressure, and an in-house prediction of every display beat.
// Depends on cdsw_pkg and countdown_stopwatch_seven_segment_unit.
`default_nettype none

module tb_countdown_stopwatch_seven_segment_unit;
  import cdsw_pkg::*;

  // Codes the block does not define; they must leave everything unchanged.
  localparam logic [2:0] MODE_RSVD_6 = 3'd6;
  localparam logic [2:0] MODE_RSVD_7 = 3'd7;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned RANDOM_CMDS = 500;

  typedef struct {
    logic [2:0]  mode;
    logic [23:0] data;
    int unsigned gap;
  } command_t;

  typedef struct {
    logic [31:0] seg_low;
    logic [15:0] seg_high;
    logic [19:0] remaining;
    logic        running;
  } display_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [2:0]  in_tuser = MODE_TICK;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;

  command_t      command_q [$];
  display_beat_t pending_displays [$];
  command_t      cur_cmd;
  display_beat_t want;

  // Shadow copy of the stopwatch state, starting at its reset values.
  logic [19:0] sw_count = COUNT_RESET;
  logic [3:0]  sw_digits [NUM_DIGITS] = '{default: 4'd0};
  logic        sw_running = 1'b1;
  logic        sw_display = 1'b1;

  bit          in_took = 1'b0;
  bit          out_took = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;
  int unsigned idle_cycles = 0;
  int unsigned accepted_cmds = 0;
  int unsigned results_seen = 0;
  int unsigned total_cmds = 0;
  int unsigned mismatches = 0;

  countdown_stopwatch_seven_segment_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Segment byte of one shown digit; anything above nine is dark.
  function automatic logic [7:0] digit_pattern(input logic [3:0] d);
    logic [7:0] lut [10];
    lut = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7c, 8'h07, 8'h7f, 8'h6f};
    return (d < 4'd10) ? lut[d] : 8'h00;
  endfunction

  // Applies one command to the shadow state and returns the beat it should produce.
  function automatic display_beat_t advance_stopwatch(input logic [2:0] mode,
                                                      input logic [23:0] data);
    display_beat_t beat;
    int unsigned   c, hs, s, m;
    logic [3:0]    mt, mo, st, so, ht, ho;
    mt = data[3:0];
    mo = data[7:4];
    st = data[11:8];
    so = data[15:12];
    ht = data[19:16];
    ho = data[23:20];
    case (mode)
      MODE_TICK: begin
        if (sw_running) begin
          c  = sw_count;
          hs = c % 100;
          s  = (c / 100) % 60;
          m  = c / 6000;
          sw_digits[DIG_HUND_ONES] = 4'(hs % 10);
          sw_digits[DIG_HUND_TENS] = 4'(hs / 10);
          sw_digits[DIG_SEC_ONES]  = 4'(s % 10);
          sw_digits[DIG_SEC_TENS]  = 4'(s / 10);
          sw_digits[DIG_MIN_ONES]  = 4'(m % 10);
          sw_digits[DIG_MIN_TENS]  = 4'(m / 10);
          if (c != 0) sw_count = 20'(c - 1);
        end
      end
      MODE_RUN:      sw_running = 1'b1;
      MODE_STOP:     sw_running = 1'b0;
      MODE_DISP_ON:  sw_display = 1'b1;
      MODE_DISP_OFF: sw_display = 1'b0;
      MODE_LOAD: begin
        // A single digit above nine throws the whole load away.
        if (mt <= 9 && mo <= 9 && st <= 9 && so <= 9 && ht <= 9 && ho <= 9) begin
          sw_digits[DIG_HUND_ONES] = ho;
          sw_digits[DIG_HUND_TENS] = ht;
          sw_digits[DIG_SEC_ONES]  = so;
          sw_digits[DIG_SEC_TENS]  = st;
          sw_digits[DIG_MIN_ONES]  = mo;
          sw_digits[DIG_MIN_TENS]  = mt;
          sw_count = 20'(((mt * 10 + mo) * 60 + st * 10 + so) * 100 + ht * 10 + ho);
        end
      end
      default: ;
    endcase
    beat.seg_low  = '0;
    beat.seg_high = '0;
    if (sw_display) begin
      beat.seg_low  = {digit_pattern(sw_digits[DIG_SEC_TENS]),
                       digit_pattern(sw_digits[DIG_SEC_ONES]),
                       digit_pattern(sw_digits[DIG_HUND_TENS]),
                       digit_pattern(sw_digits[DIG_HUND_ONES])};
      beat.seg_high = {digit_pattern(sw_digits[DIG_MIN_TENS]),
                       digit_pattern(sw_digits[DIG_MIN_ONES])};
    end
    beat.remaining = sw_count;
    beat.running   = sw_running;
    return beat;
  endfunction

  function automatic void check_field(input string label, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, label, exp_val, act_val);
      mismatches++;
    end
  endfunction

  // Queues a command; every fourth stretch of 60 commands is sent back to back.
  task automatic queue_cmd(input logic [2:0] mode, input logic [23:0] data);
    command_t cmd;
    cmd.mode = mode;
    cmd.data = data;
    cmd.gap  = ((command_q.size() / 60) % 4 == 2) ? 0 : $urandom_range(0, 19);
    command_q.push_back(cmd);
  endtask

  task automatic queue_load(input logic [3:0] mt, mo, st, so, ht, ho);
    queue_cmd(MODE_LOAD, {ho, ht, so, st, mo, mt});
  endtask

  // Input driver: holds a beat until it is taken, then waits out the drawn gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (in_gap != 0) begin
        in_tvalid <= 1'b0;
        in_gap = in_gap - 1;
      end else if (command_q.size() != 0) begin
        cur_cmd = command_q.pop_front();
        in_tuser  <= cur_cmd.mode;
        in_tdata  <= cur_cmd.data;
        in_tvalid <= 1'b1;
        in_gap = cur_cmd.gap;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: stalls for a drawn number of cycles after each taken beat.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_took)
        out_stall = ((results_seen / 50) % 3 == 1) ? 0 : $urandom_range(0, 19);
      if (out_stall != 0) begin
        out_tready <= 1'b0;
        out_stall = out_stall - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on every input beat and checks every result beat.
  always @(posedge clk) begin
    in_took  <= rst_n && in_tvalid && in_tready;
    out_took <= rst_n && out_tvalid && out_tready;
    if (rst_n && ((in_tvalid && in_tready) || (out_tvalid && out_tready)))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;

    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_displays.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got 0x%0h", $time, out_tdata);
        mismatches++;
      end else begin
        want = pending_displays.pop_front();
        check_field("segments_low", want.seg_low, out_tdata[31:0]);
        check_field("segments_high", 32'(want.seg_high), 32'(out_tdata[47:32]));
        check_field("remaining", 32'(want.remaining), 32'(out_tdata[67:48]));
        check_field("is_running", 32'(want.running), 32'(out_tdata[68]));
        check_field("padding", 32'd0, 32'(out_tdata[71:69]));
      end
    end

    if (rst_n && in_tvalid && in_tready) begin
      pending_displays.push_back(advance_stopwatch(in_tuser, in_tdata));
      accepted_cmds++;
    end
  end

  // Watchdog: too long without any beat on either side ends the run.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus and end of test.
  initial begin
    int unsigned pick;
    logic [3:0]  dg [6];

    // Directed part: extremes, every command and each corner of the countdown.
    queue_cmd(MODE_TICK, 24'h000000);
    queue_load(4'd9, 4'd9, 4'd9, 4'd9, 4'd9, 4'd9);
    queue_cmd(MODE_TICK, 24'hffffff);
    queue_load(4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd1);
    queue_cmd(MODE_TICK, 24'h000000);
    queue_cmd(MODE_TICK, 24'h000000);
    queue_cmd(MODE_DISP_OFF, 24'h000000);
    queue_cmd(MODE_TICK, 24'h000000);
    queue_load(4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6);
    queue_cmd(MODE_DISP_ON, 24'hffffff);
    queue_cmd(MODE_STOP, 24'h000000);
    queue_cmd(MODE_TICK, 24'h000000);
    queue_cmd(MODE_RUN, 24'hffffff);
    queue_cmd(MODE_TICK, 24'h000000);
    queue_load(4'd15, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
    queue_load(4'd0, 4'd12, 4'd0, 4'd0, 4'd0, 4'd0);
    queue_load(4'd0, 4'd0, 4'd10, 4'd0, 4'd0, 4'd0);
    queue_load(4'd0, 4'd0, 4'd0, 4'd11, 4'd0, 4'd0);
    queue_load(4'd0, 4'd0, 4'd0, 4'd0, 4'd14, 4'd0);
    queue_load(4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd10);
    queue_load(4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15);
    queue_cmd(MODE_RSVD_6, 24'h000000);
    queue_cmd(MODE_RSVD_7, 24'hffffff);
    queue_load(4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
    queue_cmd(MODE_TICK, 24'h000000);

    // Random part: mostly ticks and loads; run, stop, display and reserved codes mixed in.
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        queue_cmd(MODE_TICK, 24'($urandom));
      end else if (pick < 75) begin
        for (int k = 0; k < 6; k++) dg[k] = 4'($urandom_range(0, 9));
        if ($urandom_range(0, 9) == 0) begin
          // Raw digits, mostly rejected.
          for (int k = 0; k < 6; k++) dg[k] = 4'($urandom_range(0, 15));
        end else if ($urandom_range(0, 3) == 0) begin
          // A few hundredths left, so the count runs down to zero.
          for (int k = 0; k < 5; k++) dg[k] = 4'd0;
        end
        queue_load(dg[0], dg[1], dg[2], dg[3], dg[4], dg[5]);
      end else if (pick < 83) begin
        queue_cmd(MODE_RUN, 24'($urandom));
      end else if (pick < 88) begin
        queue_cmd(MODE_STOP, 24'($urandom));
      end else if (pick < 93) begin
        queue_cmd(MODE_DISP_ON, 24'($urandom));
      end else if (pick < 97) begin
        queue_cmd(MODE_DISP_OFF, 24'($urandom));
      end else begin
        queue_cmd($urandom_range(0, 1) ? MODE_RSVD_6 : MODE_RSVD_7, 24'($urandom));
      end
    end
    total_cmds = command_q.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_cmds < total_cmds || pending_displays.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
sv/cdsw_pkg.sv
sv/countdown_stopwatch_seven_segment_unit.sv
sv/cdsw_checker.sv
tb/sv/tb_countdown_stopwatch_seven_segment_unit.sv
